FILE: rtl/core/utf8_color_code_run_splitter_defines.svh
// Assertion macros used by the checker file.
`ifndef UTF8_COLOR_CODE_RUN_SPLITTER_DEFINES_SVH
`define UTF8_COLOR_CODE_RUN_SPLITTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CCRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CCRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ccrs_pkg.sv
package ccrs_pkg;

    localparam int RES_SLOTS = 4;
    localparam int SLOT_W    = 3;
    localparam int PEND_DEPTH = 3;

    localparam logic [23:0] DEFAULT_RGB_RESET = 24'hFFFFFF;

    localparam logic [7:0] SIGN_BYTE   = 8'hA7;
    localparam logic [20:0] SIGN_CP    = 21'h0000A7;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_LOWER_R  = 8'h72;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [3:0] LETTER_BASE = 4'd9;

    localparam logic [23:0] COLOR_TABLE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hFFAA00, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    typedef enum logic [1:0] {
        OP_NONE = 2'b00,
        OP_EMIT = 2'b01,
        OP_LEAD = 2'b10
    } t_slot_op;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  plain_byte;
        logic [23:0] color_rgb;
        logic        run_start;
        logic [15:0] plain_count;
        logic        line_done;
    } t_out_item;

    typedef struct packed {
        logic        awaiting;
        logic [23:0] color;
        logic        new_run;
    } t_chain;

    typedef struct packed {
        logic [1:0] pend_count;
        logic [2:0] exp_len;
        t_chain     chain;
    } t_line_state;

    localparam t_line_state LINE_STATE_RESET = '{
        pend_count: 2'd0,
        exp_len:    SEQ_NONE,
        chain:      '{awaiting: 1'b0, color: DEFAULT_RGB_RESET, new_run: 1'b1}
    };

endpackage

FILE: rtl/core/ccrs_step.sv
module ccrs_step
    import ccrs_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  t_slot_op              i_op,
    input  logic [7:0]            i_byte,
    input  logic                  i_line_end,
    input  logic [23:0]           i_default_rgb,
    input  t_chain                i_chain,
    input  logic [COUNT_BITS-1:0] i_count,
    output t_chain                o_chain,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_emit,
    output t_out_item             o_item,
    output logic                  o_open,
    output logic [2:0]            o_open_len
);

    logic [7:0] lc;
    logic [2:0] lead_len;

    assign lc = (i_byte >= CH_UPPER_A && i_byte <= CH_UPPER_Z) ? i_byte + CASE_OFFSET : i_byte;

    always_comb begin
        if ((i_byte & LEAD2_MASK) == LEAD2_TAG) begin
            lead_len = SEQ_LEN2;
        end else if ((i_byte & LEAD3_MASK) == LEAD3_TAG) begin
            lead_len = SEQ_LEN3;
        end else if ((i_byte & LEAD4_MASK) == LEAD4_TAG) begin
            lead_len = SEQ_LEN4;
        end else begin
            lead_len = SEQ_NONE;
        end
    end

    always_comb begin
        o_chain    = i_chain;
        o_count    = i_count;
        o_emit     = 1'b0;
        o_open     = 1'b0;
        o_open_len = SEQ_NONE;
        case (i_op)
            OP_EMIT: begin
                o_emit = 1'b1;
            end
            OP_LEAD: begin
                if (i_chain.awaiting) begin
                    o_chain.awaiting = 1'b0;
                    if (!i_chain.new_run) begin
                        o_chain.color = i_default_rgb;
                    end
                    o_chain.new_run = 1'b1;
                    if (lc == CH_LOWER_R) begin
                        o_chain.color = i_default_rgb;
                    end else if (lc >= CH_ZERO && lc <= CH_NINE) begin
                        o_chain.color = COLOR_TABLE[lc[3:0]];
                    end else if (lc >= CH_LOWER_A && lc <= CH_LOWER_F) begin
                        o_chain.color = COLOR_TABLE[lc[3:0] + LETTER_BASE];
                    end
                end else if (i_byte < CONT_TAG) begin
                    o_emit = 1'b1;
                end else if (lead_len != SEQ_NONE) begin
                    if (i_line_end) begin
                        o_emit = 1'b1;
                    end else begin
                        o_open     = 1'b1;
                        o_open_len = lead_len;
                    end
                end else if (i_byte == SIGN_BYTE) begin
                    o_chain.awaiting = 1'b1;
                end else begin
                    o_emit = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (o_emit) begin
            if (i_count != '1) begin
                o_count = i_count + COUNT_BITS'(1);
            end
            o_chain.new_run = 1'b0;
        end
    end

    always_comb begin
        o_item.has_byte    = 1'b1;
        o_item.plain_byte  = i_byte;
        o_item.color_rgb   = i_chain.color;
        o_item.run_start   = i_chain.new_run;
        o_item.plain_count = 16'(o_count);
        o_item.line_done   = 1'b0;
    end

endmodule

FILE: rtl/core/ccrs_decode.sv
module ccrs_decode
    import ccrs_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  t_in_item                     i_item,
    input  t_line_state                  i_state,
    input  logic [7:0]                   i_pend [PEND_DEPTH],
    input  logic [COUNT_BITS-1:0]        i_count,
    input  logic [23:0]                  i_default_rgb,
    output t_out_item [RES_SLOTS-1:0]    o_results,
    output logic [SLOT_W-1:0]            o_nres,
    output t_line_state                  o_state,
    output logic [7:0]                   o_pend [PEND_DEPTH],
    output logic [COUNT_BITS-1:0]        o_count
);

    logic [7:0]            b;
    logic                  e;
    logic [1:0]            pc;
    logic [2:0]            el;
    logic                  is_cont;
    logic                  complete;
    logic                  sign_hit;
    logic                  append;
    logic [20:0]           cp;
    t_slot_op              op [RES_SLOTS];
    logic [7:0]            sb [RES_SLOTS];
    t_chain                chain [RES_SLOTS+1];
    logic [COUNT_BITS-1:0] cnt [RES_SLOTS+1];
    logic                  emit [RES_SLOTS];
    t_out_item             item [RES_SLOTS];
    logic                  open [RES_SLOTS];
    logic [2:0]            open_len [RES_SLOTS];
    logic [SLOT_W-1:0]     n;
    logic                  open_any;
    logic [7:0]            open_b;
    logic [2:0]            open_l;

    assign b        = i_item.text_byte;
    assign e        = i_item.line_end;
    assign pc       = i_state.pend_count;
    assign el       = i_state.exp_len;
    assign is_cont  = (b & CONT_MASK) == CONT_TAG;
    assign complete = (pc != 2'd0) && is_cont && ((3'(pc) + 3'd1) >= el);

    always_comb begin
        case (el)
            SEQ_LEN2: cp = 21'({i_pend[0][4:0], b[5:0]});
            SEQ_LEN3: cp = 21'({i_pend[0][3:0], i_pend[1][5:0], b[5:0]});
            default:  cp = {i_pend[0][2:0], i_pend[1][5:0], i_pend[2][5:0], b[5:0]};
        endcase
    end

    always_comb begin
        sign_hit = 1'b0;
        append   = 1'b0;
        for (int i = 0; i < RES_SLOTS; i++) begin
            op[i] = OP_NONE;
        end
        sb[0] = i_pend[0];
        sb[1] = i_pend[1];
        sb[2] = i_pend[2];
        sb[3] = b;
        if (pc == 2'd0) begin
            op[3] = OP_LEAD;
        end else if (!is_cont || (e && !complete)) begin
            op[0] = OP_EMIT;
            op[1] = (pc >= 2'd2) ? OP_LEAD : OP_NONE;
            op[2] = (pc == 2'd3) ? OP_LEAD : OP_NONE;
            op[3] = OP_LEAD;
        end else if (complete) begin
            if (cp == SIGN_CP) begin
                sign_hit = 1'b1;
            end else begin
                op[0] = OP_EMIT;
                op[1] = (pc >= 2'd2) ? OP_EMIT : OP_NONE;
                op[2] = (pc == 2'd3) ? OP_EMIT : OP_NONE;
                op[3] = OP_EMIT;
            end
        end else begin
            append = 1'b1;
        end
    end

    assign chain[0] = i_state.chain;
    assign cnt[0]   = i_count;

    for (genvar g = 0; g < RES_SLOTS; g++) begin : g_slot
        ccrs_step #(
            .COUNT_BITS (COUNT_BITS)
        ) u_step (
            .i_op          (op[g]),
            .i_byte        (sb[g]),
            .i_line_end    (e),
            .i_default_rgb (i_default_rgb),
            .i_chain       (chain[g]),
            .i_count       (cnt[g]),
            .o_chain       (chain[g+1]),
            .o_count       (cnt[g+1]),
            .o_emit        (emit[g]),
            .o_item        (item[g]),
            .o_open        (open[g]),
            .o_open_len    (open_len[g])
        );
    end

    always_comb begin
        open_any = 1'b0;
        open_b   = '0;
        open_l   = SEQ_NONE;
        for (int i = 0; i < RES_SLOTS; i++) begin
            if (open[i]) begin
                open_any = 1'b1;
                open_b   = sb[i];
                open_l   = open_len[i];
            end
        end
    end

    always_comb begin
        o_results = '0;
        n         = '0;
        for (int i = 0; i < RES_SLOTS; i++) begin
            if (emit[i]) begin
                o_results[n[1:0]] = item[i];
                n = n + SLOT_W'(1);
            end
        end
        if (e) begin
            if (n == '0) begin
                o_results[0].plain_count = 16'(cnt[RES_SLOTS]);
                n = SLOT_W'(1);
            end
            o_results[2'(n - SLOT_W'(1))].line_done = 1'b1;
        end
        o_nres = n;
    end

    always_comb begin
        o_pend  = i_pend;
        o_state = i_state;
        o_count = cnt[RES_SLOTS];
        if (e) begin
            o_state = LINE_STATE_RESET;
            o_state.chain.color = i_default_rgb;
            o_count = '0;
        end else begin
            o_state.chain = chain[RES_SLOTS];
            if (sign_hit) begin
                o_state.chain.awaiting = 1'b1;
            end
            if (open_any) begin
                o_pend[0]          = open_b;
                o_state.pend_count = 2'd1;
                o_state.exp_len    = open_l;
            end else if (append) begin
                o_pend[pc]         = b;
                o_state.pend_count = pc + 2'd1;
            end else begin
                o_state.pend_count = 2'd0;
                o_state.exp_len    = SEQ_NONE;
            end
        end
    end

endmodule

FILE: rtl/core/utf8_color_code_run_splitter.sv
// Path: accepted items are registered in the input stage; decoded results are
// registered in the four-slot result bank. Throughput: 1 item per cycle while each
// item gives at most one result and the output is not stalled; an item with up to 4
// results holds the input while the single output port drains the bank.
// Reset: synchronous, active-low i_rst_n empties both stages, clears the line
// state and sets default_rgb and the current colour to FFFFFF.
module utf8_color_code_run_splitter
    import ccrs_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    logic                          r_in_valid;
    logic                          n_in_valid;
    t_in_item                      r_in;
    t_line_state                   r_state;
    t_line_state                   n_state;
    logic [7:0]                    r_pend [PEND_DEPTH];
    logic [7:0]                    n_pend [PEND_DEPTH];
    logic [COUNT_BITS-1:0]         r_count;
    logic [COUNT_BITS-1:0]         n_count;
    logic [23:0]                   r_default_rgb;
    t_out_item [RES_SLOTS-1:0]     r_bank;
    t_out_item [RES_SLOTS-1:0]     n_bank;
    logic [SLOT_W-1:0]             r_bank_n;
    logic [SLOT_W-1:0]             n_bank_n;
    t_out_item [RES_SLOTS-1:0]     dec_results;
    logic [SLOT_W-1:0]             dec_nres;

    logic accept;
    logic pop;
    logic bank_free;
    logic load;

    assign o_out_valid = r_bank_n != '0;
    assign o_out_item  = r_bank[0];
    assign o_cfg_ready = 1'b1;

    assign pop        = o_out_valid && !i_out_stall;
    assign bank_free  = (r_bank_n == '0) || ((r_bank_n == SLOT_W'(1)) && pop);
    assign load       = r_in_valid && bank_free;
    assign o_in_stall = r_in_valid && !load;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_in_valid = accept || (r_in_valid && !load);

    ccrs_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .i_item        (r_in),
        .i_state       (r_state),
        .i_pend        (r_pend),
        .i_count       (r_count),
        .i_default_rgb (r_default_rgb),
        .o_results     (dec_results),
        .o_nres        (dec_nres),
        .o_state       (n_state),
        .o_pend        (n_pend),
        .o_count       (n_count)
    );

    always_comb begin
        n_bank   = r_bank;
        n_bank_n = r_bank_n;
        if (load) begin
            n_bank   = dec_results;
            n_bank_n = dec_nres;
        end else if (pop) begin
            n_bank   = r_bank >> $bits(t_out_item);
            n_bank_n = r_bank_n - SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_bank_n      <= '0;
            r_state       <= LINE_STATE_RESET;
            r_count       <= '0;
            r_default_rgb <= DEFAULT_RGB_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            r_bank_n   <= n_bank_n;
            if (load) begin
                r_state <= n_state;
                r_count <= n_count;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_default_rgb <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_item;
        end
        if (load) begin
            r_pend <= n_pend;
        end
        r_bank <= n_bank;
    end

endmodule

FILE: rtl/core/ccrs_checker.sv
`include "utf8_color_code_run_splitter_defines.svh"

module ccrs_checker
    import ccrs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic r_byte_seen;
    logic n_byte_seen;

    always_comb begin
        n_byte_seen = r_byte_seen;
        if (o_out_valid && !i_out_stall) begin
            if (o_out_item.line_done) begin
                n_byte_seen = 1'b0;
            end else if (o_out_item.has_byte) begin
                n_byte_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_seen <= 1'b0;
        end else begin
            r_byte_seen <= n_byte_seen;
        end
    end

    `CCRS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "item changed while stalled")
    `CCRS_ASSERT_SAME(a_marker_shape, o_out_valid && !o_out_item.has_byte, o_out_item.line_done && o_out_item.plain_byte == 8'h00 && o_out_item.color_rgb == 24'h000000 && !o_out_item.run_start, "bare end marker malformed")
    `CCRS_ASSERT_SAME(a_first_run, o_out_valid && o_out_item.has_byte && !r_byte_seen, o_out_item.run_start, "first byte of a line lacks run start")
    `CCRS_ASSERT_SAME(a_stall_cause, o_in_stall, o_out_valid, "input held with no result waiting")

endmodule

bind utf8_color_code_run_splitter ccrs_checker u_ccrs_checker (.*);

FILE: tb/tb_utf8_color_code_run_splitter.sv
module tb_utf8_color_code_run_splitter;
    import ccrs_pkg::*;

    localparam logic [7:0] SECTION_SIGN = 8'hA7;
    localparam logic [7:0] CODE_RESTORE = "r";
    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int BATCH_ITEMS   = 32;

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hFFAA00, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    localparam logic [7:0] OPENING_LINE [20] = '{
        8'h41, 8'hC2, 8'hA7, 8'h34, 8'h00, 8'hA7, 8'h52, 8'hE0, 8'h82, 8'hA7,
        8'h46, 8'h7F, 8'hA7, 8'h7A, 8'hC3, 8'h78, 8'hFF, 8'hA7, 8'hC3, 8'h62
    };
    localparam logic [7:0] CAPPED_LINE [4] = '{8'hF0, 8'h80, 8'h80, 8'hC2};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data = '0;

    utf8_color_code_run_splitter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state mirrored for prediction
    logic [23:0] dflt_rgb = 24'hFFFFFF;
    logic [23:0] run_rgb = 24'hFFFFFF;
    logic [7:0]  held [3];
    int unsigned held_n = 0;
    int unsigned seq_len = 0;
    bit          code_next = 1'b0;
    bit          fresh_run = 1'b1;
    logic [15:0] line_count = '0;
    int unsigned step_n = 0;

    t_out_item   expected_chars [$];
    t_in_item    text_q [$];
    logic [7:0]  line_buf [$];
    string       code_chars = "0123456789abcdefABCDEFrRzX";

    int unsigned idle_pct = 33;
    int unsigned bytes_queued = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet = 0;
    logic        in_taken = 1'b0;
    t_out_item   want;
    string       diffs;

    function automatic void push_plain(logic [7:0] b);
        t_out_item r;
        if (step_n >= 4) return;
        if (line_count != 16'hFFFF) line_count++;
        r = '0;
        r.has_byte = 1'b1;
        r.plain_byte = b;
        r.color_rgb = run_rgb;
        r.run_start = fresh_run;
        r.plain_count = line_count;
        expected_chars = {expected_chars, r};
        step_n++;
        fresh_run = 1'b0;
    endfunction

    function automatic void take_code(logic [7:0] c);
        if (c >= "A" && c <= "Z") c = c + 8'd32;
        if (!fresh_run) run_rgb = dflt_rgb;
        fresh_run = 1'b1;
        if (c == CODE_RESTORE) begin
            run_rgb = dflt_rgb;
        end else if (c >= "0" && c <= "9") begin
            run_rgb = PALETTE[c[3:0]];
        end else if (c >= "a" && c <= "f") begin
            run_rgb = PALETTE[c[3:0] + 4'd9];
        end
    endfunction

    function automatic void scan_lead(logic [7:0] b);
        if (code_next) begin
            code_next = 1'b0;
            take_code(b);
        end else if (b < 8'h80) begin
            push_plain(b);
        end else if ((b & 8'hE0) == 8'hC0) begin
            held[0] = b;
            held_n = 1;
            seq_len = 2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            held[0] = b;
            held_n = 1;
            seq_len = 3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            held[0] = b;
            held_n = 1;
            seq_len = 4;
        end else if (b == SECTION_SIGN) begin
            code_next = 1'b1;
        end else begin
            push_plain(b);
        end
    endfunction

    function automatic void close_bad_seq(logic [7:0] tail, bit have_tail);
        logic [7:0]  keep [3];
        int unsigned k;
        keep = held;
        k = held_n;
        held_n = 0;
        seq_len = 0;
        if (k != 0) begin
            push_plain(keep[0]);
            for (int i = 1; i < k; i++) scan_lead(keep[i]);
        end
        if (have_tail) scan_lead(tail);
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        logic [31:0] cp;
        int unsigned k;
        if (held_n == 0) begin
            scan_lead(b);
        end else if (b[7:6] != 2'b10) begin
            close_bad_seq(b, 1'b1);
        end else if (held_n + 1 >= seq_len) begin
            case (seq_len)
                2: cp = {27'd0, held[0][4:0]};
                3: cp = {28'd0, held[0][3:0]};
                default: cp = {29'd0, held[0][2:0]};
            endcase
            k = held_n;
            for (int i = 1; i < k; i++) cp = {cp[25:0], held[i][5:0]};
            cp = {cp[25:0], b[5:0]};
            held_n = 0;
            seq_len = 0;
            if (cp == 32'(SECTION_SIGN)) begin
                code_next = 1'b1;
            end else begin
                for (int i = 0; i < k; i++) push_plain(held[i]);
                push_plain(b);
            end
        end else begin
            held[held_n] = b;
            held_n++;
        end
    endfunction

    function automatic void predict_item(t_in_item item);
        t_out_item tail_item;
        step_n = 0;
        decode_byte(item.text_byte);
        if (item.line_end) begin
            while (held_n != 0) close_bad_seq(8'h00, 1'b0);
            if (step_n == 0) begin
                tail_item = '0;
                tail_item.plain_count = line_count;
            end else begin
                tail_item = expected_chars.pop_back();
            end
            tail_item.line_done = 1'b1;
            expected_chars = {expected_chars, tail_item};
            held_n = 0;
            seq_len = 0;
            code_next = 1'b0;
            run_rgb = dflt_rgb;
            fresh_run = 1'b1;
            line_count = '0;
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic push_item(logic [7:0] b, logic last);
        t_in_item it;
        it.text_byte = b;
        it.line_end = last;
        text_q = {text_q, it};
        bytes_queued++;
    endtask

    function automatic void put_byte(logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    task automatic add_seq(int unsigned len, int unsigned conts);
        case (len)
            2: put_byte(8'hC0 | 8'($urandom_range(0, 31)));
            3: put_byte(8'hE0 | 8'($urandom_range(0, 15)));
            default: put_byte(8'hF0 | 8'($urandom_range(0, 7)));
        endcase
        repeat (conts) put_byte(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    task automatic add_sign();
        case ($urandom_range(0, 3))
            0: begin
                put_byte(8'hC2);
                put_byte(SECTION_SIGN);
            end
            1: begin
                put_byte(SECTION_SIGN);
            end
            2: begin
                put_byte(8'hE0);
                put_byte(8'h82);
                put_byte(SECTION_SIGN);
            end
            default: begin
                put_byte(8'hF0);
                put_byte(8'h80);
                put_byte(8'h82);
                put_byte(SECTION_SIGN);
            end
        endcase
    endtask

    task automatic queue_random_line();
        int unsigned kind;
        int unsigned len;
        logic [7:0]  b;
        line_buf.delete();
        repeat ($urandom_range(1, 8)) begin
            kind = $urandom_range(0, 99);
            len = $urandom_range(2, 4);
            if (kind < 30) begin
                put_byte(8'($urandom_range(0, 127)));
            end else if (kind < 55) begin
                add_seq(len, len - 1);
            end else if (kind < 75) begin
                add_sign();
                if ($urandom_range(0, 4) != 0) begin
                    put_byte(code_chars[$urandom_range(0, code_chars.len() - 1)]);
                end else begin
                    put_byte(8'($urandom));
                end
            end else if (kind < 85) begin
                add_seq(len, $urandom_range(0, len - 2));
                b = 8'($urandom);
                if (b[7:6] == 2'b10) b[7] = 1'b0;
                put_byte(b);
            end else if (kind < 92) begin
                if ($urandom_range(0, 1) != 0) begin
                    put_byte(8'h80 | 8'($urandom_range(0, 63)));
                end else begin
                    put_byte(8'hF8 | 8'($urandom_range(0, 7)));
                end
            end else begin
                put_byte(8'($urandom));
            end
        end
        kind = $urandom_range(0, 99);
        len = $urandom_range(2, 4);
        if (kind < 12) begin
            add_seq(len, $urandom_range(0, len - 2));
        end else if (kind < 20) begin
            add_sign();
        end
        foreach (line_buf[i]) push_item(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic write_default(logic [23:0] rgb);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= rgb;
        do @(posedge i_clk); while (!o_cfg_ready);
        dflt_rgb = rgb;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (text_q.size() != 0 || i_in_valid || expected_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Hold the item until taken, then advance or idle
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (text_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_in_item <= text_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_item(i_in_item);
                in_taken <= 1'b1;
            end else begin
                in_taken <= 1'b0;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected item %h", o_out_item));
                end else begin
                    want = expected_chars.pop_front();
                    diffs = "";
                    if (o_out_item.has_byte !== want.has_byte)
                        diffs = {diffs, $sformatf(" has_byte %0b/%0b",
                                 want.has_byte, o_out_item.has_byte)};
                    if (o_out_item.plain_byte !== want.plain_byte)
                        diffs = {diffs, $sformatf(" plain_byte %h/%h",
                                 want.plain_byte, o_out_item.plain_byte)};
                    if (o_out_item.color_rgb !== want.color_rgb)
                        diffs = {diffs, $sformatf(" color_rgb %h/%h",
                                 want.color_rgb, o_out_item.color_rgb)};
                    if (o_out_item.run_start !== want.run_start)
                        diffs = {diffs, $sformatf(" run_start %0b/%0b",
                                 want.run_start, o_out_item.run_start)};
                    if (o_out_item.plain_count !== want.plain_count)
                        diffs = {diffs, $sformatf(" plain_count %0d/%0d",
                                 want.plain_count, o_out_item.plain_count)};
                    if (o_out_item.line_done !== want.line_done)
                        diffs = {diffs, $sformatf(" line_done %0b/%0b",
                                 want.line_done, o_out_item.line_done)};
                    if (diffs != "") report_mismatch({"expected/got:", diffs});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned mark;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_default(24'hFFFFFF);
        for (int i = 0; i < 20; i++) push_item(OPENING_LINE[i], i == 19);
        for (int i = 0; i < 4; i++) push_item(CAPPED_LINE[i], i == 3);
        push_item(SECTION_SIGN, 1'b1);
        for (int phase = 0; phase < 3; phase++) begin
            settle();
            idle_pct = (phase == 1) ? 0 : 33;
            write_default((phase == 0) ? 24'h000000 : 24'($urandom));
            mark = bytes_queued;
            while (bytes_queued - mark < BATCH_ITEMS) queue_random_line();
        end
        settle();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
